// File: hdl/vsf_pkg.sv
// ----------------------------------------------------------------------------
// Value selection filter package
// Register indexes, mode and comparison codes and the stage flag bundle.
// ----------------------------------------------------------------------------
package vsf_pkg;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SELECT_MODE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMPARE_KIND    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_RESULT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFERENCE_VALUE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOW       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HIGH      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_STEP       = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE_WIDTH = 3'd7;

    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_SINGLE    = 3'd1;
    localparam logic [2:0] MODE_RANGE     = 3'd2;
    localparam logic [2:0] MODE_RANGE_INC = 3'd3;
    localparam logic [2:0] MODE_INC_WIDTH = 3'd4;
    localparam logic [2:0] MODE_OPERATOR  = 3'd5;
    localparam logic [2:0] MODE_ALL       = 3'd6;

    localparam logic [2:0] CMP_NONE = 3'd0;
    localparam logic [2:0] CMP_LT   = 3'd1;
    localparam logic [2:0] CMP_GT   = 3'd2;
    localparam logic [2:0] CMP_LE   = 3'd3;
    localparam logic [2:0] CMP_GE   = 3'd4;

    typedef struct packed {
        logic base_hit;
        logic grid_chk;
        logic tol_mode;
    } t_flags;

endpackage

// File: hdl/vsf_prep.sv
// ----------------------------------------------------------------------------
// Value selection filter front end
// Input register, bound differences, then mode decision and grid offset.
// ----------------------------------------------------------------------------
module vsf_prep #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [VALUE_BITS-1:0]   i_sample_value,
    input  logic [2:0]              i_select_mode,
    input  logic [2:0]              i_compare_kind,
    input  logic [VALUE_BITS-1:0]   i_reference_value,
    input  logic [VALUE_BITS-1:0]   i_range_low,
    input  logic [VALUE_BITS-1:0]   i_range_high,
    input  logic [VALUE_BITS-2:0]   i_grid_step,
    input  logic [VALUE_BITS-2:0]   i_tolerance_width,
    output logic                    o_valid,
    output vsf_pkg::t_flags         o_flags,
    output logic [VALUE_BITS:0]     o_offset
);

    localparam int VB = VALUE_BITS;

    logic                 r_s1_valid;
    logic [VB-1:0]        r_s1_value;

    logic                 r_s2_valid;
    logic signed [VB:0]   r_s2_diff_lo;
    logic signed [VB:0]   r_s2_diff_hi;
    logic                 r_s2_eq;
    logic                 r_s2_lt;

    logic                 r_s3_valid;
    vsf_pkg::t_flags      r_s3_flags;
    logic [VB:0]          r_s3_offset;

    logic signed [VB:0]   n_diff_lo;
    logic signed [VB:0]   n_diff_hi;
    logic                 n_eq;
    logic                 n_lt;

    logic signed [VB+1:0] w_lo_tol;
    logic signed [VB+1:0] w_hi_tol;
    logic                 w_in_range;
    logic                 w_wide_ok;
    logic                 w_step_nz;
    logic                 n_base;
    logic                 n_grid;
    logic                 n_tol;
    logic [VB:0]          n_offset;

    always_comb begin
        n_diff_lo = $signed({r_s1_value[VB-1], r_s1_value})
                  - $signed({i_range_low[VB-1], i_range_low});
        n_diff_hi = $signed({r_s1_value[VB-1], r_s1_value})
                  - $signed({i_range_high[VB-1], i_range_high});
        n_eq      = (r_s1_value == i_reference_value);
        n_lt      = ($signed(r_s1_value) < $signed(i_reference_value));
    end

    always_comb begin
        w_lo_tol   = $signed({r_s2_diff_lo[VB], r_s2_diff_lo})
                   + $signed({3'b000, i_tolerance_width});
        w_hi_tol   = $signed({r_s2_diff_hi[VB], r_s2_diff_hi})
                   - $signed({3'b000, i_tolerance_width});
        w_in_range = !r_s2_diff_lo[VB] && (r_s2_diff_hi[VB] || (r_s2_diff_hi == '0));
        w_wide_ok  = !w_lo_tol[VB+1] && (w_hi_tol[VB+1] || (w_hi_tol == '0));
        w_step_nz  = (i_grid_step != '0);
        n_base     = 1'b0;
        n_grid     = 1'b0;
        n_tol      = 1'b0;
        n_offset   = r_s2_diff_lo;
        case (i_select_mode)
            vsf_pkg::MODE_SINGLE: begin
                n_base = r_s2_eq;
            end
            vsf_pkg::MODE_RANGE: begin
                n_base = w_in_range;
            end
            vsf_pkg::MODE_RANGE_INC: begin
                n_grid = w_in_range && w_step_nz;
            end
            vsf_pkg::MODE_INC_WIDTH: begin
                n_grid   = w_wide_ok && w_step_nz;
                n_tol    = 1'b1;
                n_offset = w_lo_tol[VB:0];
            end
            vsf_pkg::MODE_OPERATOR: begin
                case (i_compare_kind)
                    vsf_pkg::CMP_LT: n_base = r_s2_lt;
                    vsf_pkg::CMP_GT: n_base = !r_s2_lt && !r_s2_eq;
                    vsf_pkg::CMP_LE: n_base = r_s2_lt || r_s2_eq;
                    vsf_pkg::CMP_GE: n_base = !r_s2_lt;
                    default:         n_base = 1'b0;
                endcase
            end
            vsf_pkg::MODE_ALL: begin
                n_base = 1'b1;
            end
            default: begin
                n_base = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_value          <= i_sample_value;
            r_s2_diff_lo        <= n_diff_lo;
            r_s2_diff_hi        <= n_diff_hi;
            r_s2_eq             <= n_eq;
            r_s2_lt             <= n_lt;
            r_s3_flags.base_hit <= n_base;
            r_s3_flags.grid_chk <= n_grid;
            r_s3_flags.tol_mode <= n_tol;
            r_s3_offset         <= n_offset;
        end
    end

    assign o_valid  = r_s3_valid;
    assign o_flags  = r_s3_flags;
    assign o_offset = r_s3_offset;

endmodule

// File: hdl/vsf_rem_stage.sv
// ----------------------------------------------------------------------------
// Value selection filter remainder step
// One restoring step of the grid remainder: one dividend bit per stage.
// ----------------------------------------------------------------------------
module vsf_rem_stage #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  vsf_pkg::t_flags       i_flags,
    input  logic [VALUE_BITS-2:0] i_rem,
    input  logic [VALUE_BITS:0]   i_dvd,
    input  logic [VALUE_BITS-2:0] i_step,
    output logic                  o_valid,
    output vsf_pkg::t_flags       o_flags,
    output logic [VALUE_BITS-2:0] o_rem,
    output logic [VALUE_BITS:0]   o_dvd
);

    localparam int VB = VALUE_BITS;

    logic            r_valid;
    vsf_pkg::t_flags r_flags;
    logic [VB-2:0]   r_rem;
    logic [VB:0]     r_dvd;

    logic [VB-1:0]   w_trial;
    logic [VB-1:0]   w_diff;
    logic [VB-2:0]   n_rem;

    always_comb begin
        w_trial = {i_rem, i_dvd[VB]};
        w_diff  = w_trial - {1'b0, i_step};
        n_rem   = (w_trial >= {1'b0, i_step}) ? w_diff[VB-2:0] : w_trial[VB-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_dvd   <= {i_dvd[VB-1:0], 1'b0};
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;

endmodule

// File: hdl/value_selection_filter.sv
// ----------------------------------------------------------------------------
// Value selection filter
// Throughput: one request per cycle while o_stall is low; the grid remainder is
// a chain of VALUE_BITS+1 restoring stages, one dividend bit each.
// Reset: synchronous, active low; clears valid bits and configuration registers.
// ----------------------------------------------------------------------------
module value_selection_filter #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vsf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [VALUE_BITS-1:0]             i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [VALUE_BITS-1:0]             i_sample_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_selected
);

    localparam int VB     = VALUE_BITS;
    localparam int NSTAGE = VALUE_BITS + 1;

    logic [2:0]    r_select_mode;
    logic [2:0]    r_compare_kind;
    logic          r_invert_result;
    logic [VB-1:0] r_reference_value;
    logic [VB-1:0] r_range_low;
    logic [VB-1:0] r_range_high;
    logic [VB-2:0] r_grid_step;
    logic [VB-2:0] r_tolerance_width;

    logic          r_out_valid;
    logic          r_selected;

    logic          w_adv;

    logic            w_valid [0:NSTAGE];
    vsf_pkg::t_flags w_flags [0:NSTAGE];
    logic [VB-2:0]   w_rem   [0:NSTAGE];
    logic [VB:0]     w_dvd   [0:NSTAGE];

    logic [VB-1:0]   w_limit;
    logic            n_hit;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_mode     <= '0;
            r_compare_kind    <= '0;
            r_invert_result   <= 1'b0;
            r_reference_value <= '0;
            r_range_low       <= '0;
            r_range_high      <= '0;
            r_grid_step       <= '0;
            r_tolerance_width <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsf_pkg::REG_SELECT_MODE:     r_select_mode     <= i_cfg_data[2:0];
                vsf_pkg::REG_COMPARE_KIND:    r_compare_kind    <= i_cfg_data[2:0];
                vsf_pkg::REG_INVERT_RESULT:   r_invert_result   <= i_cfg_data[0];
                vsf_pkg::REG_REFERENCE_VALUE: r_reference_value <= i_cfg_data;
                vsf_pkg::REG_RANGE_LOW:       r_range_low       <= i_cfg_data;
                vsf_pkg::REG_RANGE_HIGH:      r_range_high      <= i_cfg_data;
                vsf_pkg::REG_GRID_STEP:       r_grid_step       <= i_cfg_data[VB-2:0];
                vsf_pkg::REG_TOLERANCE_WIDTH: r_tolerance_width <= i_cfg_data[VB-2:0];
                default: begin
                end
            endcase
        end
    end

    vsf_prep #(
        .VALUE_BITS (VB)
    ) u_prep (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (w_adv),
        .i_valid           (i_valid),
        .i_sample_value    (i_sample_value),
        .i_select_mode     (r_select_mode),
        .i_compare_kind    (r_compare_kind),
        .i_reference_value (r_reference_value),
        .i_range_low       (r_range_low),
        .i_range_high      (r_range_high),
        .i_grid_step       (r_grid_step),
        .i_tolerance_width (r_tolerance_width),
        .o_valid           (w_valid[0]),
        .o_flags           (w_flags[0]),
        .o_offset          (w_dvd[0])
    );

    assign w_rem[0] = '0;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_rem
        vsf_rem_stage #(
            .VALUE_BITS (VB)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_flags (w_flags[g]),
            .i_rem   (w_rem[g]),
            .i_dvd   (w_dvd[g]),
            .i_step  (r_grid_step),
            .o_valid (w_valid[g+1]),
            .o_flags (w_flags[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_dvd   (w_dvd[g+1])
        );
    end

    always_comb begin
        w_limit = w_flags[NSTAGE].tol_mode ? {r_tolerance_width, 1'b0} : '0;
        n_hit   = w_flags[NSTAGE].base_hit
               || (w_flags[NSTAGE].grid_chk && ({1'b0, w_rem[NSTAGE]} <= w_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_selected <= n_hit ^ r_invert_result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_selected = r_selected;

endmodule
